FILE: rtl/bps_pkg.sv
`default_nettype none
package bps_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned RecipW = 25;
  localparam int unsigned NumW   = 17;
  localparam int unsigned QW     = 18;
  localparam logic [ChW-1:0] AlphaZero = 8'h00;
  localparam logic [ChW-1:0] ChMax     = 8'hFF;

  typedef logic [RecipW-1:0] recip_tab_t [256];

  // floor(2^24 / a) by restoring long division, elaboration only
  function automatic recip_tab_t gen_recip();
    recip_tab_t t;
    longint unsigned rem;
    longint unsigned q;
    for (int a = 0; a < 256; a++) begin
      rem = 0;
      q = 0;
      if (a != 0) begin
        for (int b = 24; b >= 0; b--) begin
          rem = (rem << 1) | ((b == 24) ? 64'd1 : 64'd0);
          q = q << 1;
          if (rem >= longint'(a)) begin
            rem = rem - longint'(a);
            q = q | 64'd1;
          end
        end
      end
      t[a] = q[RecipW-1:0];
    end
    return t;
  endfunction

  localparam recip_tab_t Recip = gen_recip();

  function automatic logic [ChW-1:0] lerp_ch(logic [ChW-1:0] p, logic [ChW-1:0] q,
                                             logic [ChW-1:0] f);
    logic [8:0]  w0;
    logic [16:0] s;
    w0 = 9'd256 - {1'b0, f};
    s = {8'd0, p} * {8'd0, w0} + {9'd0, q} * {9'd0, f} + 17'd128;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bilinear_premul_sampler_core.sv
// Bilinear sampler with premultiplied-alpha filtering, ARGB8888.
// Input channel: valid_i / stall_o with four neighbour pixels (already
// edge-clamped) and 8-bit fractions frac_x_i, frac_y_i.
// Output channel: valid_o / stall_i with pixel_out_o, straight alpha.
// An item moves on an edge where valid is high and stall is low.
// Throughput: one item per cycle while the output is not stalled. Stages from
// accept to valid_o: premultiply multiply, divide by 255, horizontal lerp,
// vertical lerp, then a three-stage reciprocal divide by alpha.
// The whole pipeline advances together; it holds when the output item
// is stalled, and stall_o follows stall_i in that case only. Bubbles
// are held in place with the items and are not squeezed out.
// Reset clears all valid bits; no item is in flight after reset.
`default_nettype none
module bilinear_premul_sampler_core
  import bps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] pixel_top_left_i,
  input  wire logic [31:0] pixel_top_right_i,
  input  wire logic [31:0] pixel_bottom_left_i,
  input  wire logic [31:0] pixel_bottom_right_i,
  input  wire logic [7:0]  frac_x_i,
  input  wire logic [7:0]  frac_y_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      pixel_out_o
);

  logic        en;
  logic [3:0]  v_q;
  logic [7:0]  a1_q [4];
  logic [15:0] x1_q [4][3];
  logic [7:0]  fx1_q, fy1_q, fx2_q, fy2_q, fy3_q;
  logic [31:0] pm_q [4];
  logic [31:0] top_q, bot_q, mix_q;
  logic [31:0] pin [4];

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;
  assign pin[0]  = pixel_top_left_i;
  assign pin[1]  = pixel_top_right_i;
  assign pin[2]  = pixel_bottom_left_i;
  assign pin[3]  = pixel_bottom_right_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [23:0] s;
    logic [7:0]  q;
    logic [16:0] r;
    logic [7:0]  ch [3];
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        a1_q[p] <= pin[p][31:24];
        for (int c = 0; c < 3; c++) begin
          x1_q[p][c] <= pin[p][c*8 +: 8] * pin[p][31:24] + 16'd127;
        end
      end
      fx1_q <= frac_x_i;
      fy1_q <= frac_y_i;
      // x / 255 via x*257 >> 16 plus one correction step
      for (int p = 0; p < 4; p++) begin
        for (int c = 0; c < 3; c++) begin
          s = {x1_q[p][c], 8'd0} + {8'd0, x1_q[p][c]};
          q = s[23:16];
          r = {1'b0, x1_q[p][c]} - ({1'b0, q, 8'd0} - {9'd0, q});
          ch[c] = (r >= 17'd255) ? q + 8'd1 : q;
        end
        pm_q[p] <= {a1_q[p], ch[2], ch[1], ch[0]};
      end
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      for (int c = 0; c < 4; c++) begin
        top_q[c*8 +: 8] <= lerp_ch(pm_q[0][c*8 +: 8], pm_q[1][c*8 +: 8], fx2_q);
        bot_q[c*8 +: 8] <= lerp_ch(pm_q[2][c*8 +: 8], pm_q[3][c*8 +: 8], fx2_q);
      end
      fy3_q <= fy2_q;
      for (int c = 0; c < 4; c++) begin
        mix_q[c*8 +: 8] <= lerp_ch(top_q[c*8 +: 8], bot_q[c*8 +: 8], fy3_q);
      end
    end
  end

  bps_unpremul u_unpremul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[3]),
    .pixel_i (mix_q),
    .valid_o (valid_o),
    .pixel_o (pixel_out_o)
  );

endmodule
`default_nettype wire

FILE: rtl/bps_unpremul.sv
`default_nettype none
module bps_unpremul
  import bps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] pixel_i,
  output logic             valid_o,
  output logic [31:0]      pixel_o
);

  logic [2:0]        v_q;
  logic [ChW-1:0]    a1_q, a2_q;
  logic [NumW-1:0]   n1_q [3];
  logic [NumW-1:0]   n2_q [3];
  logic [RecipW-1:0] r1_q;
  logic [QW-1:0]     qe_q [3];
  logic [31:0]       pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NumW+RecipW-1:0] prod;
    logic [QW+ChW-1:0]      qa;
    logic [QW+ChW-1:0]      rem;
    logic [QW-1:0]          qc;
    logic [ChW-1:0]         res [3];
    if (en_i) begin
      a1_q <= pixel_i[31:24];
      r1_q <= Recip[pixel_i[31:24]];
      for (int c = 0; c < 3; c++) begin
        n1_q[c] <= {1'b0, pixel_i[c*8 +: 8], 8'd0} - {9'd0, pixel_i[c*8 +: 8]}
                   + {10'd0, pixel_i[31:25]};
      end
      a2_q <= a1_q;
      for (int c = 0; c < 3; c++) begin
        prod = {{RecipW{1'b0}}, n1_q[c]} * {{NumW{1'b0}}, r1_q};
        qe_q[c] <= prod[24 +: QW];
        n2_q[c] <= n1_q[c];
      end
      for (int c = 0; c < 3; c++) begin
        qa  = qe_q[c] * {{QW{1'b0}}, a2_q};
        rem = {{(QW+ChW-NumW){1'b0}}, n2_q[c]} - qa;
        qc  = (rem >= {{QW{1'b0}}, a2_q}) ? qe_q[c] + 1'b1 : qe_q[c];
        res[c] = (qc > {{(QW-ChW){1'b0}}, ChMax}) ? ChMax : qc[ChW-1:0];
      end
      if (a2_q == AlphaZero) begin
        pix_q <= '0;
      end else begin
        pix_q <= {a2_q, res[2], res[1], res[0]};
      end
    end
  end

  assign valid_o = v_q[2];
  assign pixel_o = pix_q;

endmodule
`default_nettype wire

FILE: rtl/bps_checker.sv
`default_nettype none
module bps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [31:0] pixel_out_o
);

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall without stalled output");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o) else $error("output item dropped");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> $stable(pixel_out_o)) else $error("stalled item changed");

  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && pixel_out_o[31:24] == 8'd0) |-> (pixel_out_o == 32'd0))
    else $error("zero alpha with color");

endmodule

bind bilinear_premul_sampler_core bps_checker u_bps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .stall_o     (stall_o),
  .valid_o     (valid_o),
  .stall_i     (stall_i),
  .pixel_out_o (pixel_out_o)
);
`default_nettype wire

FILE: tb/bilinear_premul_sampler_checker.sv
`timescale 1ns / 100ps
module bilinear_premul_sampler_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic        stall_o,
  input  wire logic [31:0] pixel_top_left_i,
  input  wire logic [31:0] pixel_top_right_i,
  input  wire logic [31:0] pixel_bottom_left_i,
  input  wire logic [31:0] pixel_bottom_right_i,
  input  wire logic [7:0]  frac_x_i,
  input  wire logic [7:0]  frac_y_i,
  input  wire logic        valid_o,
  input  wire logic        stall_i,
  input  wire logic [31:0] pixel_out_o,
  output int               errors_o,
  output int               pending_o
);

  logic [31:0] pixel_q[$];

  function automatic logic [31:0] premultiply(logic [31:0] px);
    logic [7:0] a;
    logic [31:0] r;
    a = px[31:24];
    if (a == 8'd0) return 32'd0;
    if (a == 8'hFF) return px;
    r[31:24] = a;
    for (int i = 0; i < 3; i++) r[i*8 +: 8] = 8'((32'(px[i*8 +: 8]) * a + 127) / 255);
    return r;
  endfunction

  function automatic logic [31:0] mix_pixel(logic [31:0] p, logic [31:0] q, logic [7:0] f);
    logic [31:0] r;
    for (int i = 0; i < 4; i++)
      r[i*8 +: 8] = 8'((32'(p[i*8 +: 8]) * (256 - f) + 32'(q[i*8 +: 8]) * f + 128) >> 8);
    return r;
  endfunction

  function automatic logic [31:0] unpremultiply(logic [31:0] px);
    logic [7:0] a;
    logic [31:0] r;
    int unsigned v;
    a = px[31:24];
    if (a == 8'd0) return 32'd0;
    if (a == 8'hFF) return px;
    r[31:24] = a;
    for (int i = 0; i < 3; i++) begin
      v = (32'(px[i*8 +: 8]) * 255 + (a >> 1)) / a;
      r[i*8 +: 8] = (v > 255) ? 8'hFF : 8'(v);
    end
    return r;
  endfunction

  function automatic logic [31:0] predict_pixel(logic [31:0] tl, logic [31:0] tr,
                                                logic [31:0] bl, logic [31:0] br,
                                                logic [7:0] fx, logic [7:0] fy);
    return unpremultiply(mix_pixel(mix_pixel(premultiply(tl), premultiply(tr), fx),
                                   mix_pixel(premultiply(bl), premultiply(br), fx), fy));
  endfunction

  initial errors_o = 0;
  assign pending_o = pixel_q.size();

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel_out %h", $time, pixel_out_o);
          errors_o++;
        end else begin
          want = pixel_q.pop_front();
          if (want !== pixel_out_o) begin
            $display("%0t: pixel_out expected %h actual %h", $time, want, pixel_out_o);
            errors_o++;
          end
        end
      end
      if (valid_i && !stall_o)
        pixel_q.push_back(predict_pixel(pixel_top_left_i, pixel_top_right_i,
                                        pixel_bottom_left_i, pixel_bottom_right_i,
                                        frac_x_i, frac_y_i));
    end
  end

endmodule

FILE: tb/bilinear_premul_sampler_core_tb.sv
`timescale 1ns / 100ps
module bilinear_premul_sampler_core_tb;

  logic clk = 1'b0, rst_n = 1'b0;
  logic valid_i = 1'b0, stall_i = 1'b0;
  logic stall_o, valid_o;
  logic [31:0] tl = '0, tr = '0, bl = '0, br = '0, pixel_out;
  logic [7:0] fx = '0, fy = '0;
  int errors, pending, cycles = 0;
  logic stall_on = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bilinear_premul_sampler_core dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_i), .stall_o(stall_o),
    .pixel_top_left_i(tl), .pixel_top_right_i(tr), .pixel_bottom_left_i(bl),
    .pixel_bottom_right_i(br), .frac_x_i(fx), .frac_y_i(fy),
    .valid_o(valid_o), .stall_i(stall_i), .pixel_out_o(pixel_out)
  );

  bilinear_premul_sampler_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_i), .stall_o(stall_o),
    .pixel_top_left_i(tl), .pixel_top_right_i(tr), .pixel_bottom_left_i(bl),
    .pixel_bottom_right_i(br), .frac_x_i(fx), .frac_y_i(fy),
    .valid_o(valid_o), .stall_i(stall_i), .pixel_out_o(pixel_out),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output-side stall: random wait per item, sometimes none
  always @(negedge clk) begin
    int unsigned w;
    if (stall_on) begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w != 0) begin
        stall_i <= 1'b1;
        repeat (w) @(negedge clk);
        stall_i <= 1'b0;
      end
      @(posedge clk);
      while (!valid_o) @(posedge clk);
    end
  end

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      2: p[31:24] = 8'(p[31:24] & 8'h03);
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic [7:0] x, logic [7:0] y, int unsigned gap);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tl <= a; tr <= b; bl <= c; br <= d; fx <= x; fy <= y;
    valid_i <= 1'b1;
    @(posedge clk);
    while (stall_o) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_back_to_back(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                   logic [31:0] d, logic [7:0] x, logic [7:0] y);
    tl <= a; tr <= b; bl <= c; br <= d; fx <= x; fy <= y;
    valid_i <= 1'b1;
    @(posedge clk);
    while (stall_o) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] p0;
    int unsigned gap;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_item('0, '0, '0, '0, 8'd0, 8'd0, 0);
    send_item('1, '1, '1, '1, 8'hFF, 8'hFF, 0);
    send_item(32'hFF123456, 32'h00FFFFFF, 32'h80FF00FF, 32'h01FFFFFF, 8'd0, 8'd0, 1);
    send_item(32'hFF123456, 32'h00FFFFFF, 32'h80FF00FF, 32'h01FFFFFF, 8'hFF, 8'd0, 0);
    send_item(32'hFF123456, 32'h00FFFFFF, 32'h80FF00FF, 32'h01FFFFFF, 8'd0, 8'hFF, 2);
    send_item(32'h01FFFFFF, 32'h00000000, 32'h00000000, 32'h00000000, 8'd0, 8'd0, 0);
    send_item(32'h01FFFFFF, 32'h02FFFFFF, 32'h01FF00FF, 32'h03FFFFFF, 8'd128, 8'd128, 0);
    send_item(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 8'd1, 8'd1, 0);
    send_item(32'h7F808080, 32'h80FFFFFF, 32'hFE7F7F7F, 32'hFFAA55AA, 8'd64, 8'd192, 3);
    send_item(32'h0AFFFFFF, 32'h0BFFFFFF, 32'h0CFFFFFF, 32'h0DFFFFFF, 8'd77, 8'd33, 0);
    stall_on = 1'b1;
    for (int n = 0; n < 1950; n++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (n % 400 < 40) gap = 0;
      p0 = rand_pixel();
      if (n == 900) begin
        valid_i <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      if (gap == 0 && $urandom_range(0, 1))
        send_back_to_back(p0, ($urandom_range(0, 1) ? p0 : rand_pixel()), rand_pixel(),
                          rand_pixel(), 8'($urandom), 8'($urandom));
      else
        send_item(p0, rand_pixel(), rand_pixel(), rand_pixel(),
                  8'($urandom), 8'($urandom), gap);
    end
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
